@@ sv/lebenc_pkg.sv @@
package lebenc_pkg;

   // Fixed widths of the stream payloads.
   localparam int LEB_INPUT_WIDTH  = 64;
   localparam int LEB_DIGIT_WIDTH  = 5;
   localparam int LEB_REQ_TDATA_W  = 72;
   localparam int LEB_RSP_TDATA_W  = 8;

   // Encoding limits.
   localparam int LEB_VALUE_WIDTH  = 64;
   localparam int LEB_MAX_DIGITS   = 16;
   localparam int LEB_MAX_BYTES    = 10;
   localparam int LEB_INDEX_WIDTH  = 4;

   // Byte layout constants.
   localparam logic [6:0] LEB_GROUP_MASK = 7'h7f;
   localparam logic [7:0] LEB_MORE_BIT   = 8'h80;
   localparam int         LEB_SIGN_BIT   = 6;

   // Encoding modes carried on the request tuser.
   localparam logic LEB_FUNC_UNSIGNED = 1'b0;
   localparam logic LEB_FUNC_SIGNED   = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic emit;
   } lebenc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fin;
   } lebenc_status_type;

   // Index of the final byte, ceil(4*digits/7) - 1, for a clamped digit count.
   function automatic logic [LEB_INDEX_WIDTH-1:0] last_index(
      input logic [LEB_DIGIT_WIDTH-1:0] digits
   );
      logic [LEB_INDEX_WIDTH-1:0] idx;
      case (digits)
         5'd1:            idx = 4'd0;
         5'd2, 5'd3:      idx = 4'd1;
         5'd4, 5'd5:      idx = 4'd2;
         5'd6, 5'd7:      idx = 4'd3;
         5'd8:            idx = 4'd4;
         5'd9, 5'd10:     idx = 4'd5;
         5'd11, 5'd12:    idx = 4'd6;
         5'd13, 5'd14:    idx = 4'd7;
         5'd15:           idx = 4'd8;
         default:         idx = 4'd9;
      endcase
      return idx;
   endfunction

endpackage

@@ sv/lebenc_ctrl.sv @@
module lebenc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output lebenc_pkg::lebenc_cmd_type    cmd,
   input  lebenc_pkg::lebenc_status_type status
);
   import lebenc_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // The output register can take a byte when it is empty or being drained.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.load = req_tvalid && req_tready;
   assign cmd.emit = (state_ff == ST_EMIT) && slot_free;

   // Next state and output valid.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.emit && status.fin) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/lebenc_dpath.sv @@
module lebenc_dpath #(
   parameter int VALUE_WIDTH = lebenc_pkg::LEB_VALUE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   req_func,
   input  logic [lebenc_pkg::LEB_INPUT_WIDTH-1:0] req_value,
   input  logic [lebenc_pkg::LEB_DIGIT_WIDTH-1:0] req_digits,
   input  lebenc_pkg::lebenc_cmd_type              cmd,
   output lebenc_pkg::lebenc_status_type           status,
   output logic [7:0]                             code_byte,
   output logic                                   code_last
);
   import lebenc_pkg::*;

   logic [VALUE_WIDTH-1:0]     value_ff, value_in;
   logic                       signed_ff;
   logic [LEB_INDEX_WIDTH-1:0] index_ff;
   logic [LEB_INDEX_WIDTH-1:0] last_idx_ff;
   logic [7:0]                 byte_ff;
   logic                       last_ff;

   logic [LEB_DIGIT_WIDTH-1:0] digits;
   logic [VALUE_WIDTH-1:0]     digit_mask;
   logic [VALUE_WIDTH-1:0]     shifted;
   logic [6:0]                 part;
   logic                       neg;
   logic                       fin;

   // Clamp the digit count to the range the literal can have.
   always_comb begin
      if (req_digits == '0) begin
         digits = LEB_DIGIT_WIDTH'(1);
      end else if (req_digits > LEB_DIGIT_WIDTH'(LEB_MAX_DIGITS)) begin
         digits = LEB_DIGIT_WIDTH'(LEB_MAX_DIGITS);
      end else begin
         digits = req_digits;
      end
   end

   // In unsigned mode keep only the bits that a literal of this many hex digits can hold; signed values pass unmasked.
   always_comb begin
      for (int i = 0; i < VALUE_WIDTH; i++) begin
         digit_mask[i] = (7'(i) < {digits, 2'b00});
      end
      if (req_func == LEB_FUNC_SIGNED) begin
         value_in = req_value[VALUE_WIDTH-1:0];
      end else begin
         value_in = req_value[VALUE_WIDTH-1:0] & digit_mask;
      end
   end

   // Current group, the value after it, and the end test.
   assign neg     = signed_ff && value_ff[VALUE_WIDTH-1];
   assign part    = value_ff[6:0] & LEB_GROUP_MASK;
   assign shifted = {{7{neg}}, value_ff[VALUE_WIDTH-1:7]};

   always_comb begin
      if (signed_ff) begin
         fin = (!neg && (shifted == '0) && !part[LEB_SIGN_BIT]) ||
               (neg && (shifted == '1) && part[LEB_SIGN_BIT]) ||
               (index_ff == LEB_INDEX_WIDTH'(LEB_MAX_BYTES - 1));
      end else begin
         fin = (index_ff == last_idx_ff);
      end
   end

   assign status.fin = fin;

   // Value shift register, byte index and output register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff    <= value_in;
         signed_ff   <= (req_func == LEB_FUNC_SIGNED);
         index_ff    <= '0;
         last_idx_ff <= last_index(digits);
      end else if (cmd.emit) begin
         value_ff <= shifted;
         index_ff <= index_ff + 1'b1;
      end
      if (cmd.emit) begin
         byte_ff <= {1'b0, part} | (fin ? 8'h00 : LEB_MORE_BIT);
         last_ff <= fin;
      end
   end

   assign code_byte = byte_ff;
   assign code_last = last_ff;

endmodule

@@ sv/leb128_byte_encoder_unit.sv @@
// Channel | Direction | Transfer contents
// req     | in        | tdata[63:0] value, tdata[68:64] digit_count; tuser func
// rsp     | out       | tdata[7:0] code_byte; tlast marks the final byte
//
// An accepted value is loaded into the shift register, then produces one byte
// per cycle while rsp_tready is high: ceil(4*digits/7) bytes in unsigned mode,
// 1 to 10 in signed mode, set by the single shift register that gives up one
// 7-bit group per cycle. A new value is accepted only once the final byte of
// the last one has moved to the output register. A stall on rsp holds the
// output register and pauses the shifting. Reset is synchronous and clears the
// controller and the output valid.
module leb128_byte_encoder_unit #(
   parameter int VALUE_WIDTH = lebenc_pkg::LEB_VALUE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // value [63:0], digit_count [68:64], zero fill [71:69]
   input  logic [lebenc_pkg::LEB_REQ_TDATA_W-1:0] req_tdata,
   // func [0]
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // code_byte [7:0]
   output logic [lebenc_pkg::LEB_RSP_TDATA_W-1:0] rsp_tdata,
   output logic                                   rsp_tlast
);
   import lebenc_pkg::*;

   lebenc_cmd_type    cmd;
   lebenc_status_type status;

   // Sequencing of loads and byte transfers.
   lebenc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Value shifting and byte formation.
   lebenc_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .req_func   (req_tuser),
      .req_value  (req_tdata[LEB_INPUT_WIDTH-1:0]),
      .req_digits (req_tdata[LEB_INPUT_WIDTH +: LEB_DIGIT_WIDTH]),
      .cmd        (cmd),
      .status     (status),
      .code_byte  (rsp_tdata),
      .code_last  (rsp_tlast)
   );

endmodule

@@ bench/leb128_byte_encoder_unit_tb.sv @@
module leb128_byte_encoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lebenc_pkg::*;

   localparam int N_DIR_ROWS   = 24;
   localparam int N_RAND_ITEMS = 256;
   localparam int MAX_SHOWN    = 10;

   // One directed row; typed_n of zero means the predictor supplies the bytes.
   typedef struct packed {
      logic        func;
      logic [63:0] value;
      logic [4:0]  digits;
      logic [3:0]  typed_n;
      logic [79:0] typed_bytes;
   } dir_row_type;

   // One encoded byte as it should leave the rsp channel.
   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } leb_byte_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_RANDOM,
      RDY_SPARSE,
      RDY_DENSE
   } ready_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [LEB_REQ_TDATA_W-1:0] req_tdata;
   logic                       req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [LEB_RSP_TDATA_W-1:0] rsp_tdata;
   logic                       rsp_tlast;

   leb_byte_type encoded_q[$];
   int           mismatch_count = 0;
   int           burst_left     = 0;

   leb128_byte_encoder_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Directed rows: extremes, both modes and every special case of the encoding.
   function automatic dir_row_type dir_row(input int idx);
      dir_row_type r;
      case (idx)
         // Unsigned mode.
         0:  r = '{LEB_FUNC_UNSIGNED, 64'h0, 5'd1, 4'd1, 80'h00};
         1:  r = '{LEB_FUNC_UNSIGNED, 64'hf, 5'd1, 4'd1, 80'h0f};
         2:  r = '{LEB_FUNC_UNSIGNED, '1, 5'd16, 4'd10, 80'h01_ff_ff_ff_ff_ff_ff_ff_ff_ff};
         // A digit count of zero counts as one digit.
         3:  r = '{LEB_FUNC_UNSIGNED, '1, 5'd0, 4'd1, 80'h0f};
         // Digit counts above the maximum saturate.
         4:  r = '{LEB_FUNC_UNSIGNED, '1, 5'd31, 4'd0, 80'h0};
         5:  r = '{LEB_FUNC_UNSIGNED, '1, 5'd17, 4'd0, 80'h0};
         // Value bits above the literal are dropped.
         6:  r = '{LEB_FUNC_UNSIGNED, 64'h123, 5'd2, 4'd2, 80'h00_a3};
         // Leading zero digits still produce bytes.
         7:  r = '{LEB_FUNC_UNSIGNED, 64'h0, 5'd16, 4'd10, 80'h00_80_80_80_80_80_80_80_80_80};
         8:  r = '{LEB_FUNC_UNSIGNED, 64'h7f, 5'd2, 4'd0, 80'h0};
         9:  r = '{LEB_FUNC_UNSIGNED, 64'h80, 5'd3, 4'd0, 80'h0};
         10: r = '{LEB_FUNC_UNSIGNED, 64'h0123_4567_89ab_cdef, 5'd16, 4'd0, 80'h0};
         11: r = '{LEB_FUNC_UNSIGNED, 64'hfedc_ba98_7654_3210, 5'd15, 4'd0, 80'h0};
         12: r = '{LEB_FUNC_UNSIGNED, 64'ha5a5_a5a5_a5a5_a5a5, 5'd8, 4'd0, 80'h0};
         13: r = '{LEB_FUNC_UNSIGNED, 64'h5a5a_5a5a_5a5a_5a5a, 5'd7, 4'd0, 80'h0};
         // Signed mode; the digit count must have no effect here.
         14: r = '{LEB_FUNC_SIGNED, 64'h0, 5'd31, 4'd1, 80'h00};
         15: r = '{LEB_FUNC_SIGNED, '1, 5'd1, 4'd1, 80'h7f};
         16: r = '{LEB_FUNC_SIGNED, 64'h3f, 5'd0, 4'd1, 80'h3f};
         17: r = '{LEB_FUNC_SIGNED, 64'h40, 5'd16, 4'd2, 80'h00_c0};
         18: r = '{LEB_FUNC_SIGNED, 64'hffff_ffff_ffff_ffc0, 5'd5, 4'd1, 80'h40};
         19: r = '{LEB_FUNC_SIGNED, 64'hffff_ffff_ffff_ffbf, 5'd9, 4'd2, 80'h7f_bf};
         20: r = '{LEB_FUNC_SIGNED, 64'h7fff_ffff_ffff_ffff, 5'd16, 4'd0, 80'h0};
         21: r = '{LEB_FUNC_SIGNED, 64'h8000_0000_0000_0000, 5'd16, 4'd10,
                   80'h7f_80_80_80_80_80_80_80_80_80};
         22: r = '{LEB_FUNC_SIGNED, 64'h0123_4567_89ab_cdef, 5'd3, 4'd0, 80'h0};
         default: r = '{LEB_FUNC_SIGNED, 64'hfedc_ba98_7654_3210, 5'd12, 4'd0, 80'h0};
      endcase
      return r;
   endfunction

   // Works out the byte stream of one value and appends it to the queue.
   function automatic void encode_value(
      input logic        func,
      input logic [63:0] value,
      input logic [4:0]  digits
   );
      logic [63:0] v;
      logic [6:0]  part;
      logic        neg;
      logic        fin;
      int          d;
      int          n;
      int          k;
      v = value;
      if (func == LEB_FUNC_UNSIGNED) begin
         d = digits;
         if (d == 0) d = 1;
         if (d > LEB_MAX_DIGITS) d = LEB_MAX_DIGITS;
         if (4 * d < 64) v = v & ((64'd1 << (4 * d)) - 64'd1);
         n = (4 * d + 6) / 7;
         for (k = 0; k < n; k++) begin
            encoded_q.push_back('{{(k != n - 1), v[6:0]}, (k == n - 1)});
            v = v >> 7;
         end
      end else begin
         // Minimal two's-complement form: stop once the rest is pure sign.
         neg = v[63];
         fin = 1'b0;
         k   = 0;
         while (!fin) begin
            part = v[6:0];
            v    = {{7{neg}}, v[63:7]};
            fin  = (!neg && v == '0 && !part[6]) || (neg && v == '1 && part[6]);
            if (k == LEB_MAX_BYTES - 1) fin = 1'b1;
            encoded_q.push_back('{{~fin, part}, fin});
            k++;
         end
      end
   endfunction

   // Presents one value and waits for its transfer, then records what must come out.
   task automatic send_value(
      input logic        func,
      input logic [63:0] value,
      input logic [4:0]  digits,
      input logic [3:0]  typed_n,
      input logic [79:0] typed_bytes
   );
      int k;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {3'b000, digits, value};
      req_tuser  = func;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      if (typed_n == 0) begin
         encode_value(func, value, digits);
      end else begin
         for (k = 0; k < typed_n; k++) begin
            encoded_q.push_back('{typed_bytes[8*k +: 8], (k == typed_n - 1)});
         end
      end
   endtask

   // Sender pacing: bursts of random length, random gaps, often no gap at all.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(12, 1);
         gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Receiver stalls follow a rotating pattern, redrawn with a random mode after each random-length stretch.
   initial begin
      ready_mode_type mode;
      logic [31:0]    pattern;
      int             stretch;
      rsp_tready = 1'b0;
      mode       = RDY_ALWAYS;
      pattern    = '1;
      stretch    = 0;
      forever begin
         @(negedge clock);
         if (stretch == 0) begin
            stretch = $urandom_range(300, 50);
            mode    = ready_mode_type'($urandom_range(3, 0));
            case (mode)
               RDY_ALWAYS: pattern = '1;
               RDY_RANDOM: pattern = $urandom;
               RDY_SPARSE: pattern = $urandom & $urandom;
               default:    pattern = $urandom | $urandom;
            endcase
            if (pattern == '0) pattern[0] = 1'b1;
         end
         stretch--;
         pattern    = {pattern[0], pattern[31:1]};
         rsp_tready = pattern[0];
      end
   end

   // Check each byte transfer against the oldest prediction.
   always @(posedge clock) begin
      leb_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (encoded_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
               $display("mismatch: unexpected byte %02h last %0b at %0t",
                        rsp_tdata, rsp_tlast, $realtime);
         end else begin
            want = encoded_q.pop_front();
            if (want.code !== rsp_tdata || want.last !== rsp_tlast) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("mismatch: byte exp %02h last %0b, got %02h last %0b at %0t",
                           want.code, want.last, rsp_tdata, rsp_tlast, $realtime);
            end
         end
      end
   end

   // Main sequence: reset, directed table, random values, drain.
   initial begin
      dir_row_type        row;
      logic               func;
      logic [63:0]        value;
      logic signed [63:0] sext;
      logic [4:0]         digits;
      int                 i;
      int                 sh;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < N_DIR_ROWS; i++) begin
         row = dir_row(i);
         send_value(row.func, row.value, row.digits, row.typed_n, row.typed_bytes);
         pace_sender();
      end

      for (i = 0; i < N_RAND_ITEMS; i++) begin
         func = 1'($urandom_range(1, 0));
         case ($urandom_range(3, 0))
            0: value = {$urandom, $urandom};
            1: value = 64'($urandom_range(255, 0));
            // Values around a power of two, either sign.
            2: begin
               value = (64'd1 << $urandom_range(63, 0)) + 64'($urandom_range(2, 0)) - 64'd1;
               if ($urandom_range(1, 0) == 1) value = -value;
            end
            // Random values sign-extended from a random bit.
            default: begin
               sh    = $urandom_range(62, 0);
               sext  = {$urandom, $urandom} << sh;
               value = sext >>> sh;
            end
         endcase
         if ($urandom_range(9, 0) == 0) digits = 5'($urandom_range(31, 0));
         else digits = 5'($urandom_range(LEB_MAX_DIGITS, 1));
         send_value(func, value, digits, 4'd0, 80'h0);
         pace_sender();
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (encoded_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      if (mismatch_count == 0 && encoded_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
